// ===== rtl/utf8je_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8je_pkg
// Shared types, character codes and helpers of the UTF-8 to JSON escaper.
// ----------------------------------------------------------------------------
package utf8je_pkg;

   // body kinds of one command
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_CHAR  = 3'd1;
   localparam logic [2:0] KIND_HEX   = 3'd2;
   localparam logic [2:0] KIND_PAIR  = 3'd3;
   localparam logic [2:0] KIND_CLOSE = 3'd4;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_QMARK  = 8'h3f;
   localparam logic [7:0] CHAR_U      = 8'h75;

   localparam logic [15:0] HIGH_SURR = 16'hd800;
   localparam logic [15:0] LOW_SURR  = 16'hdc00;
   localparam logic [20:0] PLANE1    = 21'h10000;

   // everything one input byte expands to
   typedef struct packed {
      logic        open_q;   // leading quote of a new string
      logic [2:0]  q_count;  // replacement characters
      logic [2:0]  kind;     // body that follows
      logic [15:0] hi;       // char in [7:0], or first escape word
      logic [15:0] lo;       // second escape word
   } cmd_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (8'h30 + {4'b0, nib}) : (8'h57 + {4'b0, nib});
   endfunction

endpackage

// ===== rtl/utf8je_front.sv =====
// ----------------------------------------------------------------------------
// utf8je_front
// Decodes the byte stream and turns each byte into at most one output command.
// ----------------------------------------------------------------------------
module utf8je_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   output utf8je_pkg::cmd_type cmd,
   output logic               cmd_push
);

   logic        open_ff, open_in;
   logic [1:0]  needed_ff, needed_in;
   logic [1:0]  held_ff, held_in;
   logic [20:0] partial_ff, partial_in;

   logic        emit;
   logic [20:0] code;
   logic [20:0] shifted;
   logic [20:0] diff;
   logic [2:0]  flush_q;

   always_comb begin
      open_in    = open_ff;
      needed_in  = needed_ff;
      held_in    = held_ff;
      partial_in = partial_ff;
      emit       = 1'b0;
      code       = '0;
      shifted    = {partial_ff[14:0], in_byte[5:0]};
      cmd        = '0;
      cmd.open_q = !open_ff;
      flush_q    = (needed_ff != 2'd0) ? ({1'b0, held_ff} + 3'd1) : 3'd0;

      if (in_byte == 8'h00) begin
         cmd.q_count = flush_q;
         cmd.kind    = utf8je_pkg::KIND_CLOSE;
         open_in     = 1'b0;
         needed_in   = 2'd0;
         held_in     = 2'd0;
         partial_in  = '0;
      end else begin
         open_in = 1'b1;
         if (needed_ff != 2'd0 && in_byte[7:6] == 2'b10) begin
            if (needed_ff == 2'd1) begin
               emit       = 1'b1;
               code       = shifted;
               needed_in  = 2'd0;
               held_in    = 2'd0;
               partial_in = '0;
            end else begin
               needed_in  = needed_ff - 2'd1;
               held_in    = held_ff + 2'd1;
               partial_in = shifted;
            end
         end else begin
            // no sequence pending, or pending sequence broken: byte is then taken afresh
            cmd.q_count = flush_q;
            needed_in   = 2'd0;
            held_in     = 2'd0;
            partial_in  = '0;
            priority if (!in_byte[7]) begin
               emit = 1'b1;
               code = {13'b0, in_byte};
            end else if (in_byte >= 8'hc2 && in_byte <= 8'hdf) begin
               partial_in = {16'b0, in_byte[4:0]};
               needed_in  = 2'd1;
            end else if (in_byte >= 8'he0 && in_byte <= 8'hef) begin
               partial_in = {17'b0, in_byte[3:0]};
               needed_in  = 2'd2;
            end else if (in_byte >= 8'hf0 && in_byte <= 8'hf4) begin
               partial_in = {18'b0, in_byte[2:0]};
               needed_in  = 2'd3;
            end else begin
               cmd.q_count = flush_q + 3'd1;
            end
         end
      end

      diff = code - utf8je_pkg::PLANE1;
      if (emit) begin
         priority if (code >= 21'h20 && code <= 21'h7e && code != 21'h22 && code != 21'h5c)
         begin
            cmd.kind = utf8je_pkg::KIND_CHAR;
            cmd.hi   = {8'b0, code[7:0]};
         end else if (code <= 21'hffff) begin
            cmd.kind = utf8je_pkg::KIND_HEX;
            cmd.hi   = code[15:0];
         end else begin
            cmd.kind = utf8je_pkg::KIND_PAIR;
            cmd.hi   = utf8je_pkg::HIGH_SURR + {5'b0, diff[20:10]};
            cmd.lo   = utf8je_pkg::LOW_SURR + {6'b0, diff[9:0]};
         end
      end

      cmd_push = accept &&
                 (cmd.open_q || cmd.q_count != 3'd0 || cmd.kind != utf8je_pkg::KIND_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         needed_ff  <= 2'd0;
         held_ff    <= 2'd0;
         partial_ff <= '0;
      end else if (accept) begin
         open_ff    <= open_in;
         needed_ff  <= needed_in;
         held_ff    <= held_in;
         partial_ff <= partial_in;
      end
   end

endmodule

// ===== rtl/utf8je_queue.sv =====
// ----------------------------------------------------------------------------
// utf8je_queue
// Small command queue between the decoder and the character sequencer.
// ----------------------------------------------------------------------------
module utf8je_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  utf8je_pkg::cmd_type push_cmd,
   input  logic                pop,
   output utf8je_pkg::cmd_type head,
   output logic                empty,
   output logic                full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   utf8je_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_CNT);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ((wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? ((rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("pop from empty queue");

endmodule

// ===== rtl/utf8je_back.sv =====
// ----------------------------------------------------------------------------
// utf8je_back
// Expands the head command into characters, one per cycle while the receiver
// is ready, into an output register.
// ----------------------------------------------------------------------------
module utf8je_back (
   input  logic                clock,
   input  logic                reset,
   input  utf8je_pkg::cmd_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_run_last
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic [3:0] idx_ff, idx_in;

   logic        load;
   logic [3:0]  qmark_end;
   logic [3:0]  body_len;
   logic [3:0]  total;
   logic [3:0]  j;
   logic [3:0]  k;
   logic [15:0] word;

   always_comb begin
      qmark_end = {3'b0, head.open_q} + {1'b0, head.q_count};
      unique case (head.kind)
         utf8je_pkg::KIND_CHAR:  body_len = 4'd1;
         utf8je_pkg::KIND_CLOSE: body_len = 4'd1;
         utf8je_pkg::KIND_HEX:   body_len = 4'd6;
         utf8je_pkg::KIND_PAIR:  body_len = 4'd12;
         default:                body_len = 4'd0;
      endcase
      total = qmark_end + body_len;
      j     = idx_ff - qmark_end;
      k     = (j >= 4'd6) ? (j - 4'd6) : j;
      word  = (j >= 4'd6) ? head.lo : head.hi;

      // position within the run picks quote, replacement or body character
      priority if (idx_ff == 4'd0 && head.open_q) begin
         char_in = utf8je_pkg::CHAR_QUOTE;
      end else if (idx_ff < qmark_end) begin
         char_in = utf8je_pkg::CHAR_QMARK;
      end else if (head.kind == utf8je_pkg::KIND_CHAR) begin
         char_in = head.hi[7:0];
      end else if (head.kind == utf8je_pkg::KIND_CLOSE) begin
         char_in = utf8je_pkg::CHAR_QUOTE;
      end else begin
         unique case (k)
            4'd0:    char_in = utf8je_pkg::CHAR_BSLASH;
            4'd1:    char_in = utf8je_pkg::CHAR_U;
            4'd2:    char_in = utf8je_pkg::hex_char(word[15:12]);
            4'd3:    char_in = utf8je_pkg::hex_char(word[11:8]);
            4'd4:    char_in = utf8je_pkg::hex_char(word[7:4]);
            default: char_in = utf8je_pkg::hex_char(word[3:0]);
         endcase
      end

      load         = !empty && (!out_valid_ff || rsp_ready);
      last_in      = (idx_ff == total - 4'd1);
      pop          = load && last_in;
      idx_in       = load ? (last_in ? 4'd0 : idx_ff + 4'd1) : idx_ff;
      out_valid_in = load ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_run_last = last_ff;

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      !empty |-> idx_ff < total) else $error("run index past end of command");
   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid && rsp_run_last) else $error("command retired without last mark");

endmodule

// ===== rtl/utf8_to_json_string_escaper_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_json_string_escaper_core
// UTF-8 byte stream in, JSON quoted string characters out.
// ----------------------------------------------------------------------------
// Input channel req_*: one text byte per transfer, zero ends the string.
// Output channel rsp_*: one output character per transfer; rsp_run_last marks
// the last character caused by an input byte. Bytes that only start or
// continue a UTF-8 sequence in an open string cause no output transfer.
// A taken byte's command is written into the command queue, and its
// characters then reach rsp through the output register. The decoder takes
// one byte per cycle while the command queue (QUEUE_DEPTH entries) has room;
// the output side delivers one character per cycle while rsp_ready is high,
// so a byte that expands to a run of characters (12 for a surrogate-pair
// escape) holds the sequencer on its command for the whole run, and the
// queue absorbs those runs before req_ready drops.
// When the receiver stalls, the held character waits in the output register,
// the queue fills and then req_ready goes low.
// Reset empties the queue and the output register and returns the decoder to
// no string open and no sequence pending.
// ----------------------------------------------------------------------------
module utf8_to_json_string_escaper_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last
);

   utf8je_pkg::cmd_type front_cmd;
   utf8je_pkg::cmd_type head_cmd;
   logic front_push;
   logic queue_empty;
   logic queue_full;
   logic back_pop;
   logic req_xfer;

   assign req_ready = !queue_full;
   assign req_xfer  = req_valid && req_ready;

   utf8je_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_xfer),
      .in_byte  (req_in_byte),
      .cmd      (front_cmd),
      .cmd_push (front_push)
   );

   utf8je_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_cmd (front_cmd),
      .pop      (back_pop),
      .head     (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   utf8je_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head_cmd),
      .empty        (queue_empty),
      .pop          (back_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last)
   );

endmodule
